>>> rtl/bee_pkg.sv
// ----------------------------------------------------------------------------
// bee_pkg
// Shared constants and types for the byte entropy estimator.
// ----------------------------------------------------------------------------
package bee_pkg;
  localparam int COUNT_BITS_DEF = 24;
  localparam int BINS = 256;
  localparam int BIN_AW = 8;
  localparam int LOG_FRAC = 16;
  localparam int OUT_FRAC = 12;
  localparam int ENT_W = 16;
  localparam int TOTAL_W = 24;
  localparam logic [ENT_W-1:0] ENT_MAX = 16'd32768;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic clr_start;   // start clearing sweep
    logic walk_start;  // start bin walk
    logic log_start;   // start log of selected operand
    logic log_sel_n;   // 1: log of n, 0: log of current bin
    logic acc_bin;     // accumulate c*L(c)
    logic acc_whole;   // form n*L(n)
    logic div_start;   // start final division
    logic bin_next;    // advance walk address
  } bee_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic walk_last;
    logic bin_zero;
    logic log_done;
    logic div_done;
  } bee_sts_t;
endpackage

>>> rtl/bee_if.sv
// ----------------------------------------------------------------------------
// bee_in_if / bee_out_if
// Valid/ready channels for input bytes and entropy results.
// ----------------------------------------------------------------------------
interface bee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface bee_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] entropy_bits;
  logic [23:0] byte_total;
  modport source (output valid, entropy_bits, byte_total, input ready);
  modport sink (input valid, entropy_bits, byte_total, output ready);
endinterface

>>> rtl/byte_entropy_estimator_unit.sv
// ----------------------------------------------------------------------------
// byte_entropy_estimator_unit
// Shannon entropy of a byte stream, in bits per byte.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into a 256-bin histogram held in a RAM. After
// the byte flagged last, the block walks all 256 bins (an empty bin is skipped,
// a used one waits on the shared iterative log2 unit), takes log2 of the
// count, then runs an 18-step divider. The result is loaded into an output
// register as soon as that register is free, and a clearing sweep of the
// histogram RAM then runs before the next byte is taken. After reset the same
// sweep runs first.
module byte_entropy_estimator_unit import bee_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bee_in_if.sink    in_ch,
  bee_out_if.source out_ch
);
  bee_cmd_t             cmd;
  bee_sts_t             sts;
  logic                 hist_busy, out_load, byte_we;
  logic [ENT_W-1:0]     entropy;
  logic [TOTAL_W-1:0]   total;
  logic                 out_valid_r;
  logic [ENT_W-1:0]     ent_r;
  logic [TOTAL_W-1:0]   tot_r;

  assign byte_we = in_ch.valid && in_ch.ready;

  bee_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_last(in_ch.last_byte),
    .in_ready(in_ch.ready), .hist_busy(hist_busy), .sts(sts), .cmd(cmd),
    .out_load(out_load), .out_free(!out_valid_r || out_ch.ready)
  );

  bee_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .byte_we(byte_we), .byte_val(in_ch.data_byte),
    .cmd(cmd), .sts(sts), .hist_busy(hist_busy), .entropy(entropy), .total(total)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ent_r <= entropy;
      tot_r <= total;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entropy_bits = ent_r;
  assign out_ch.byte_total   = tot_r;
endmodule

>>> rtl/bee_ram.sv
// ----------------------------------------------------------------------------
// bee_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bee_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/bee_datapath.sv
// ----------------------------------------------------------------------------
// bee_datapath
// Histogram memory, byte count, iterative log2, accumulators and divider.
// ----------------------------------------------------------------------------
module bee_datapath import bee_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_we,      // byte accepted this cycle
  input  logic [7:0]            byte_val,
  input  bee_cmd_t              cmd,
  output bee_sts_t              sts,
  output logic                  hist_busy,    // read-modify-write in flight
  output logic [ENT_W-1:0]      entropy,
  output logic [TOTAL_W-1:0]    total
);
  localparam int EW = $clog2(COUNT_BITS);
  localparam int LW = EW + LOG_FRAC;            // log2 width
  localparam int PW = COUNT_BITS + LW;          // product width
  localparam int SW = PW + BIN_AW;              // sum width
  localparam int QW = ENT_W + 2;                // quotient bits
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // histogram memory, pipelined read-modify-write (registered read, then write-back)
  logic                  we;
  logic [BIN_AW-1:0]     waddr, raddr;
  logic [COUNT_BITS-1:0] wdata, rdata;
  logic                  upd_r;
  logic [BIN_AW-1:0]     upd_addr_r;
  logic                  fwd_r;       // previous update hits same bin
  logic [COUNT_BITS-1:0] last_wr_r;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  clearing_r;
  logic [BIN_AW:0]       clr_cnt_r;
  logic [BIN_AW:0]       walk_addr_r;
  logic [COUNT_BITS-1:0] n_r;

  bee_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cur_cnt = fwd_r ? last_wr_r : rdata;
  assign raddr   = byte_we ? byte_val : walk_addr_r[BIN_AW-1:0];
  assign hist_busy = upd_r;

  always_comb begin
    we = 1'b0;
    waddr = upd_addr_r;
    wdata = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    if (clearing_r) begin
      we = 1'b1;
      waddr = clr_cnt_r[BIN_AW-1:0];
      wdata = '0;
    end else if (upd_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= 1'b0;
      fwd_r <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r <= '0;
      n_r <= '0;
    end else begin
      upd_r <= byte_we;
      fwd_r <= byte_we && upd_r && (byte_val == upd_addr_r);
      if (byte_we && n_r != CNT_MAX) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.clr_start) begin
        clearing_r <= 1'b1;
        clr_cnt_r <= '0;
        n_r <= '0;
      end else if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r[BIN_AW-1:0] == BIN_AW'(BINS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    upd_addr_r <= byte_val;
    if (upd_r) begin
      last_wr_r <= wdata;
    end
  end

  assign sts.clr_done = !clearing_r;

  // bin walk address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_addr_r <= '0;
    end else if (cmd.walk_start) begin
      walk_addr_r <= '0;
    end else if (cmd.bin_next) begin
      walk_addr_r <= walk_addr_r + 1'b1;
    end
  end
  assign sts.walk_last = walk_addr_r[BIN_AW];
  assign sts.bin_zero  = (rdata == '0);

  // iterative log2: leading-one search one bit a cycle, then 16 squarings
  typedef enum logic [3:0] {
    LG_IDLE = 4'b0001, LG_NORM = 4'b0010, LG_SQ = 4'b0100, LG_DONE = 4'b1000
  } lg_state_t;
  lg_state_t             lg_st_r;
  logic [COUNT_BITS-1:0] x_r;         // operand
  logic [EW-1:0]         e_r;
  logic [31:0]           m_r;         // 1.31
  logic [LOG_FRAC-1:0]   f_r;
  logic [4:0]            it_r;
  logic [63:0]           sq;
  logic [32:0]           sq_sh;

  // 32x32 square of the mantissa
  assign sq    = 64'(m_r) * 64'(m_r);
  assign sq_sh = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_st_r <= LG_IDLE;
    end else begin
      unique case (lg_st_r)
        LG_IDLE: if (cmd.log_start) lg_st_r <= LG_NORM;
        LG_NORM: if (x_r[COUNT_BITS-1]) lg_st_r <= LG_SQ;
        LG_SQ:   if (it_r == 5'd15) lg_st_r <= LG_DONE;
        LG_DONE: lg_st_r <= LG_IDLE;
        default: lg_st_r <= LG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (lg_st_r == LG_IDLE && cmd.log_start) begin
      x_r  <= cmd.log_sel_n ? n_r : rdata;
      e_r  <= EW'(COUNT_BITS - 1);
      it_r <= '0;
      f_r  <= '0;
    end else if (lg_st_r == LG_NORM) begin
      if (!x_r[COUNT_BITS-1]) begin
        x_r <= x_r << 1;
        e_r <= e_r - 1'b1;
      end else begin
        m_r <= 32'(x_r) << (32 - COUNT_BITS);
      end
    end else if (lg_st_r == LG_SQ) begin
      it_r <= it_r + 1'b1;
      if (sq_sh[32]) begin
        m_r <= sq_sh[32:1];
        f_r <= {f_r[LOG_FRAC-2:0], 1'b1};
      end else begin
        m_r <= sq_sh[31:0];
        f_r <= {f_r[LOG_FRAC-2:0], 1'b0};
      end
    end
  end
  assign sts.log_done = (lg_st_r == LG_DONE);

  logic [LW-1:0] lval;
  assign lval = {e_r, f_r};

  // accumulators
  logic [SW-1:0] s_r;
  logic [PW-1:0] whole_r;

  // x_r was normalized; recover count from the snapshot kept separately
  logic [COUNT_BITS-1:0] opnd_r;
  always_ff @(posedge clk) begin
    if (lg_st_r == LG_IDLE && cmd.log_start) begin
      opnd_r <= cmd.log_sel_n ? n_r : rdata;
    end
  end
  logic [PW-1:0] prod;
  assign prod = PW'(opnd_r) * PW'(lval);

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      s_r <= '0;
    end else if (cmd.acc_bin) begin
      s_r <= s_r + SW'(prod);
    end
    if (cmd.acc_whole) begin
      whole_r <= prod;
    end
  end

  // restoring divider: q = (D + 8n) / (16n), one quotient bit a cycle
  logic [SW:0]           rem_r;
  logic [QW-1:0]         q_r;
  logic [4:0]            dcnt_r;
  logic                  dbusy_r, ddone_r;
  logic [SW:0]           dvs_sh;
  logic [SW:0]           num;
  logic [SW:0]           dvs;
  assign dvs = (SW+1)'({n_r, 4'b0});
  assign num = (SW'(whole_r) < s_r) ? (SW+1)'({n_r, 3'b0})
             : (SW+1)'(SW'(whole_r) - s_r) + (SW+1)'({n_r, 3'b0});
  assign dvs_sh = dvs << dcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dcnt_r == '0) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= num;
      q_r    <= '0;
      dcnt_r <= 5'(QW - 1);
    end else if (dbusy_r) begin
      if (rem_r >= dvs_sh) begin
        rem_r <= rem_r - dvs_sh;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
  end
  assign sts.div_done = ddone_r;

  // quotient is QW bits wide; values above ENT_MAX saturate to ENT_MAX
  assign entropy = (q_r > QW'(ENT_MAX)) ? ENT_MAX : q_r[ENT_W-1:0];
  generate
    if (COUNT_BITS > TOTAL_W) begin : g_tw
      assign total = (n_r > COUNT_BITS'(TOTAL_MAX)) ? TOTAL_MAX : n_r[TOTAL_W-1:0];
    end else begin : g_tn
      assign total = TOTAL_W'(n_r);
    end
  endgenerate
endmodule

>>> rtl/bee_ctrl.sv
// ----------------------------------------------------------------------------
// bee_ctrl
// Sequencer for histogram fill, bin walk, division and result handoff.
// ----------------------------------------------------------------------------
module bee_ctrl import bee_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  logic     hist_busy,
  input  bee_sts_t sts,
  output bee_cmd_t cmd,
  output logic     out_load,
  input  logic     out_free
);
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_FILL  = 11'b00000000010,
    S_DRAIN = 11'b00000000100,
    S_RD    = 11'b00000001000,
    S_CHK   = 11'b00000010000,
    S_LOG   = 11'b00000100000,
    S_ACC   = 11'b00001000000,
    S_NLOG  = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_WAIT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } st_t;
  st_t st_r, st_nxt;

  assign in_ready = (st_r == S_FILL);

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    out_load = 1'b0;
    unique case (st_r)
      S_CLEAR: if (sts.clr_done) st_nxt = S_FILL;
      S_FILL:  if (in_valid && in_last) st_nxt = S_DRAIN;
      S_DRAIN: if (!hist_busy) begin
        cmd.walk_start = 1'b1;
        st_nxt = S_RD;
      end
      S_RD: st_nxt = S_CHK;
      S_CHK: begin
        if (sts.walk_last) begin
          cmd.log_start = 1'b1;
          cmd.log_sel_n = 1'b1;
          st_nxt = S_NLOG;
        end else if (sts.bin_zero) begin
          cmd.bin_next = 1'b1;
          st_nxt = S_RD;
        end else begin
          cmd.log_start = 1'b1;
          st_nxt = S_LOG;
        end
      end
      S_LOG: if (sts.log_done) st_nxt = S_ACC;
      S_ACC: begin
        cmd.acc_bin = 1'b1;
        cmd.bin_next = 1'b1;
        st_nxt = S_RD;
      end
      S_NLOG: if (sts.log_done) begin
        cmd.acc_whole = 1'b1;
        st_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT: if (sts.div_done) st_nxt = S_OUT;
      S_OUT: if (out_free) begin
        out_load = 1'b1;
        cmd.clr_start = 1'b1;
        st_nxt = S_CLEAR;
      end
      default: st_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end
endmodule
